/* hw/rtl/docu_pkg.sv */
// Shared types and constants for the dissolved oxygen compensation unit.
// Used by the register block, the serial arithmetic units and the top level.
package docu_pkg;

    localparam int TEMP_MAX_DEF = 50;

    localparam int MUL_A_W = 44;
    localparam int MUL_B_W = 31;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 40;
    localparam int DIV_D_W = 16;

    localparam logic [15:0] SLOPE_RESET = 16'd644;
    localparam logic [29:0] POW_STEP    = 30'd1012791180;
    localparam logic [29:0] HALF_Q30    = 30'h2000_0000;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [18:0] SAL_A       = 19'd398721;
    localparam logic [19:0] SAL_B       = 20'd202113;
    localparam logic [24:0] CUB_C1      = 25'd29500551;
    localparam logic [19:0] CUB_C2      = 20'd554376;
    localparam logic [12:0] CUB_C3      = 13'd4878;
    localparam logic [10:0] DO_FULL     = 11'd1462;
    localparam logic [9:0]  SAT_SCALE   = 10'd1000;
    localparam logic [15:0] PRESS_REF   = 16'd760;

    typedef enum logic [1:0] {
        MODE_READ      = 2'd0,
        MODE_CAL_ATM   = 2'd1,
        MODE_CAL_ZERO  = 2'd2,
        MODE_CAL_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_TEMP     = 2'd0,
        REG_PRESSURE = 2'd1,
        REG_SALINITY = 2'd2,
        REG_NONE     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [5:0]  temperature;
        logic [10:0] pressure;
        logic [5:0]  salinity;
        logic        coeff_stale;
    } cfg_t;

endpackage

/* hw/rtl/docu_regs.sv */
// APB configuration registers: temperature, pressure and salinity.
// Depends on docu_pkg; flags a write that invalidates the cached coefficients.
module docu_regs
    import docu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [5:0]  temp_reg, temp_next;
    logic [10:0] press_reg, press_next;
    logic [5:0]  sal_reg, sal_next;
    logic        stale_reg, stale_next;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        temp_next  = temp_reg;
        press_next = press_reg;
        sal_next   = sal_reg;
        stale_next = 1'b0;
        if (wr_en)
        begin
            case (idx)
                REG_TEMP:
                begin
                    temp_next  = pwdata[5:0];
                    stale_next = 1'b1;
                end
                REG_PRESSURE: press_next = pwdata[10:0];
                REG_SALINITY:
                begin
                    sal_next   = pwdata[5:0];
                    stale_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg  <= 6'd20;
            press_reg <= 11'd760;
            sal_reg   <= 6'd0;
            stale_reg <= 1'b0;
        end
        else
        begin
            temp_reg  <= temp_next;
            press_reg <= press_next;
            sal_reg   <= sal_next;
            stale_reg <= stale_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_TEMP:     prdata = {26'd0, temp_reg};
            REG_PRESSURE: prdata = {21'd0, press_reg};
            REG_SALINITY: prdata = {26'd0, sal_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.temperature = temp_reg;
    assign cfg.pressure    = press_reg;
    assign cfg.salinity    = sal_reg;
    assign cfg.coeff_stale = stale_reg;

endmodule

/* hw/rtl/docu_serial_mult.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on docu_pkg for operand widths; stops early when the multiplier runs out.
module docu_serial_mult
    import docu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] acc_reg, acc_next;
    logic [MUL_P_W-1:0] a_reg, a_next;
    logic [MUL_B_W-1:0] b_reg, b_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = MUL_P_W'(a);
            b_next    = b;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[MUL_P_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[MUL_B_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* hw/rtl/docu_serial_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on docu_pkg for dividend and divisor widths.
module docu_serial_div
    import docu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_N_W-1:0] q_reg, q_next;
    logic [DIV_D_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               fits;

    assign trial = {rem_reg, q_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            q_next   = dividend;
            d_next   = divisor;
            cnt_next = CNT_W'(DIV_N_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            q_next   = {q_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* hw/rtl/dissolved_oxygen_compensation_unit.sv */
// Calibration items pass through S_DONE to the output registers, which out_stall can hold.
// A read item runs two 40-bit serial divisions and four shift-add multiplications; when the
// base is negative it ends after the second multiplication, skipping the last two and the
// second division. A read after reset or after a temperature or salinity write first
// recomputes the cached terms, with one power-step multiplication per degree of clamped temperature.
// Reset is asynchronous and active low; it restores default calibration and registers.
module dissolved_oxygen_compensation_unit
    import docu_pkg::*;
#(
    parameter int TempMax = TEMP_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [15:0] probe_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] oxygen_level,
    output logic [15:0] saturation_level,
    output logic [1:0]  cal_count,
    output logic        slope_error
);

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_POW   = 17'h00002,
        S_POW_W = 17'h00004,
        S_COEF  = 17'h00008,
        S_TERM  = 17'h00010,
        S_T2    = 17'h00020,
        S_T3    = 17'h00040,
        S_C1    = 17'h00080,
        S_C2    = 17'h00100,
        S_C3    = 17'h00200,
        S_DIV   = 17'h00400,
        S_SAT   = 17'h00800,
        S_BASE  = 17'h01000,
        S_COMP  = 17'h02000,
        S_PRES  = 17'h04000,
        S_DIV2  = 17'h08000,
        S_DONE  = 17'h10000
    } state_t;

    localparam logic [6:0] TMAX = 7'(TempMax);
    localparam logic signed [33:0] CUB_ONE = 34'sh040000000;

    cfg_t cfg;

    state_t state_reg, state_next;
    logic [15:0] slope_reg, slope_next;
    logic [15:0] zero_reg, zero_next;
    logic [15:0] diff_reg, diff_next;
    logic [30:0] p_reg, p_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [11:0] t2_reg, t2_next;
    logic [17:0] t3_reg, t3_next;
    logic signed [33:0] cub_reg, cub_next;
    logic [25:0] term_reg, term_next;
    logic [16:0] cubic16_reg, cubic16_next;
    logic        cache_ok_reg, cache_ok_next;
    logic [31:0] r_reg, r_next;
    logic [15:0] oxy_res_reg, oxy_res_next;
    logic [15:0] sat_res_reg, sat_res_next;
    logic        err_res_reg, err_res_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_oxy_reg, out_oxy_next;
    logic [15:0] out_sat_reg, out_sat_next;
    logic [1:0]  out_cnt_reg, out_cnt_next;
    logic        out_err_reg, out_err_next;

    logic               mul_go_reg, mul_go_next;
    logic [MUL_A_W-1:0] mul_a_reg, mul_a_next;
    logic [MUL_B_W-1:0] mul_b_reg, mul_b_next;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_prod;
    logic               div_go_reg, div_go_next;
    logic [DIV_N_W-1:0] div_n_reg, div_n_next;
    logic [DIV_D_W-1:0] div_d_reg, div_d_next;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;

    logic [5:0]  t_clamp;
    logic [60:0] p_sum;
    logic [19:0] coef;
    logic signed [33:0] cub_prod;
    logic signed [33:0] cub_fin;
    logic [42:0] b1;
    logic        accept;
    logic        out_free;

    docu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    docu_serial_mult u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_go_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    docu_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_n_reg),
        .divisor  (div_d_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign t_clamp  = ({1'b0, cfg.temperature} > TMAX) ? TMAX[5:0] : cfg.temperature;
    assign p_sum    = mul_prod[60:0] + 61'(HALF_Q30);
    assign coef     = {1'b0, mul_prod[48:30]} + SAL_B;
    assign cub_prod = $signed({1'b0, mul_prod[32:0]});
    assign cub_fin  = cub_reg - cub_prod;
    assign b1       = mul_prod[42:0];
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        slope_next    = slope_reg;
        zero_next     = zero_reg;
        diff_next     = diff_reg;
        p_next        = p_reg;
        cnt_next      = cnt_reg;
        t2_next       = t2_reg;
        t3_next       = t3_reg;
        cub_next      = cub_reg;
        term_next     = term_reg;
        cubic16_next  = cubic16_reg;
        cache_ok_next = cache_ok_reg && !cfg.coeff_stale;
        r_next        = r_reg;
        oxy_res_next  = oxy_res_reg;
        sat_res_next  = sat_res_reg;
        err_res_next  = err_res_reg;
        mul_go_next   = 1'b0;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        div_go_next   = 1'b0;
        div_n_next    = div_n_reg;
        div_d_next    = div_d_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_oxy_next  = out_oxy_reg;
        out_sat_next  = out_sat_reg;
        out_cnt_next  = out_cnt_reg;
        out_err_next  = out_err_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    oxy_res_next = '0;
                    sat_res_next = '0;
                    err_res_next = 1'b0;
                    state_next   = S_DONE;
                    case (mode_t'(mode))
                        MODE_READ:
                        begin
                            if (slope_reg == '0)
                            begin
                                err_res_next = 1'b1;
                            end
                            else if (probe_sample >= zero_reg)
                            begin
                                diff_next = probe_sample - zero_reg;
                                if (cache_ok_reg && !cfg.coeff_stale)
                                begin
                                    div_go_next = 1'b1;
                                    div_n_next  = {8'd0, probe_sample - zero_reg, 16'd0};
                                    div_d_next  = slope_reg;
                                    state_next  = S_DIV;
                                end
                                else
                                begin
                                    p_next     = ONE_Q30;
                                    cnt_next   = t_clamp;
                                    state_next = S_POW;
                                end
                            end
                        end
                        MODE_CAL_ATM:  slope_next = probe_sample;
                        MODE_CAL_ZERO: zero_next  = probe_sample;
                        default:
                        begin
                            slope_next = SLOPE_RESET;
                            zero_next  = '0;
                        end
                    endcase
                end
            end
            S_POW:
            begin
                mul_go_next = 1'b1;
                mul_b_next  = p_reg;
                if (cnt_reg == '0)
                begin
                    mul_a_next = MUL_A_W'(SAL_A);
                    state_next = S_COEF;
                end
                else
                begin
                    mul_a_next = MUL_A_W'(POW_STEP);
                    state_next = S_POW_W;
                end
            end
            S_POW_W:
            begin
                if (mul_done)
                begin
                    p_next     = p_sum[60:30];
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_POW;
                end
            end
            S_COEF:
            begin
                if (mul_done)
                begin
                    mul_go_next = 1'b1;
                    mul_a_next  = MUL_A_W'(coef);
                    mul_b_next  = MUL_B_W'(cfg.salinity);
                    state_next  = S_TERM;
                end
            end
            S_TERM:
            begin
                if (mul_done)
                begin
                    term_next   = mul_prod[25:0];
                    mul_go_next = 1'b1;
                    mul_a_next  = MUL_A_W'(t_clamp);
                    mul_b_next  = MUL_B_W'(t_clamp);
                    state_next  = S_T2;
                end
            end
            S_T2:
            begin
                if (mul_done)
                begin
                    t2_next     = mul_prod[11:0];
                    mul_go_next = 1'b1;
                    mul_a_next  = MUL_A_W'(mul_prod[11:0]);
                    mul_b_next  = MUL_B_W'(t_clamp);
                    state_next  = S_T3;
                end
            end
            S_T3:
            begin
                if (mul_done)
                begin
                    t3_next     = mul_prod[17:0];
                    mul_go_next = 1'b1;
                    mul_a_next  = MUL_A_W'(CUB_C1);
                    mul_b_next  = MUL_B_W'(t_clamp);
                    state_next  = S_C1;
                end
            end
            S_C1:
            begin
                if (mul_done)
                begin
                    cub_next    = CUB_ONE - cub_prod;
                    mul_go_next = 1'b1;
                    mul_a_next  = MUL_A_W'(CUB_C2);
                    mul_b_next  = MUL_B_W'(t2_reg);
                    state_next  = S_C2;
                end
            end
            S_C2:
            begin
                if (mul_done)
                begin
                    cub_next    = cub_reg + cub_prod;
                    mul_go_next = 1'b1;
                    mul_a_next  = MUL_A_W'(CUB_C3);
                    mul_b_next  = MUL_B_W'(t3_reg);
                    state_next  = S_C3;
                end
            end
            S_C3:
            begin
                if (mul_done)
                begin
                    cubic16_next  = cub_fin[33] ? 17'd0 : cub_fin[30:14];
                    cache_ok_next = !cfg.coeff_stale;
                    div_go_next   = 1'b1;
                    div_n_next    = {8'd0, diff_reg, 16'd0};
                    div_d_next    = slope_reg;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    r_next      = div_q[31:0];
                    mul_go_next = 1'b1;
                    mul_a_next  = MUL_A_W'(div_q[31:0]);
                    mul_b_next  = MUL_B_W'(SAT_SCALE);
                    state_next  = S_SAT;
                end
            end
            S_SAT:
            begin
                if (mul_done)
                begin
                    sat_res_next = (|mul_prod[MUL_P_W-1:32]) ? 16'hFFFF : mul_prod[31:16];
                    mul_go_next  = 1'b1;
                    mul_a_next   = MUL_A_W'(r_reg);
                    mul_b_next   = MUL_B_W'(DO_FULL);
                    state_next   = S_BASE;
                end
            end
            S_BASE:
            begin
                if (mul_done)
                begin
                    if (b1 < {17'd0, term_reg})
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mul_go_next = 1'b1;
                        mul_a_next  = MUL_A_W'(b1 - {17'd0, term_reg});
                        mul_b_next  = MUL_B_W'(cubic16_reg);
                        state_next  = S_COMP;
                    end
                end
            end
            S_COMP:
            begin
                if (mul_done)
                begin
                    mul_go_next = 1'b1;
                    mul_a_next  = mul_prod[59:16];
                    mul_b_next  = MUL_B_W'(cfg.pressure);
                    state_next  = S_PRES;
                end
            end
            S_PRES:
            begin
                if (mul_done)
                begin
                    div_go_next = 1'b1;
                    div_n_next  = {1'b0, mul_prod[54:16]};
                    div_d_next  = PRESS_REF;
                    state_next  = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    oxy_res_next = (|div_q[DIV_N_W-1:16]) ? 16'hFFFF : div_q[15:0];
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_oxy_next   = oxy_res_reg;
                    out_sat_next   = sat_res_reg;
                    out_err_next   = err_res_reg;
                    out_cnt_next   = {1'b0, slope_reg != SLOPE_RESET}
                                   + {1'b0, zero_reg != 16'd0};
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slope_reg     <= SLOPE_RESET;
            zero_reg      <= '0;
            cache_ok_reg  <= 1'b0;
            mul_go_reg    <= 1'b0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slope_reg     <= slope_next;
            zero_reg      <= zero_next;
            cache_ok_reg  <= cache_ok_next;
            mul_go_reg    <= mul_go_next;
            div_go_reg    <= div_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg    <= diff_next;
        p_reg       <= p_next;
        cnt_reg     <= cnt_next;
        t2_reg      <= t2_next;
        t3_reg      <= t3_next;
        cub_reg     <= cub_next;
        term_reg    <= term_next;
        cubic16_reg <= cubic16_next;
        r_reg       <= r_next;
        oxy_res_reg <= oxy_res_next;
        sat_res_reg <= sat_res_next;
        err_res_reg <= err_res_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        div_n_reg   <= div_n_next;
        div_d_reg   <= div_d_next;
        out_oxy_reg <= out_oxy_next;
        out_sat_reg <= out_sat_next;
        out_cnt_reg <= out_cnt_next;
        out_err_reg <= out_err_next;
    end

    assign out_valid        = out_valid_reg;
    assign oxygen_level     = out_oxy_reg;
    assign saturation_level = out_sat_reg;
    assign cal_count        = out_cnt_reg;
    assign slope_error      = out_err_reg;

endmodule

/* hw/rtl/docu_checker.sv */
// Port-level checks for the dissolved oxygen compensation unit.
// Bound to the top level; depends on no package.
module docu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] oxygen_level,
    input logic [15:0] saturation_level,
    input logic [1:0]  cal_count,
    input logic        slope_error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Result item dropped while stalled.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Input taken again before the item finished.");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slope_error |-> oxygen_level == 16'd0 && saturation_level == 16'd0)
        else $error("Slope error with nonzero readings.");

    a_cal_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cal_count != 2'd3)
        else $error("Calibration count out of range.");

endmodule

bind dissolved_oxygen_compensation_unit docu_checker u_docu_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .oxygen_level     (oxygen_level),
    .saturation_level (saturation_level),
    .cal_count        (cal_count),
    .slope_error      (slope_error)
);

/* sim/testbench.sv */
// Self-checking testbench for the dissolved oxygen compensation unit.
// Drives probe items and register writes, predicts each result and compares it field by field.
// Depends on docu_pkg and dissolved_oxygen_compensation_unit.

class oxygen_scoreboard;
    logic [5:0]  temperature;
    logic [10:0] pressure;
    logic [5:0]  salinity;
    logic [15:0] slope;
    logic [15:0] zero_offset;
    logic [15:0] exp_oxygen[$];
    logic [15:0] exp_saturation[$];
    logic [1:0]  exp_count[$];
    logic        exp_error[$];
    int          errors;
    int          checked;

    function void clear_state();
        temperature = 6'd20;
        pressure    = 11'd760;
        salinity    = 6'd0;
        slope       = docu_pkg::SLOPE_RESET;
        zero_offset = 16'd0;
        errors      = 0;
        checked     = 0;
    endfunction

    function void compensate(input logic [15:0] sample, output logic [15:0] oxy,
                             output logic [15:0] sat);
        longint t;
        longint ratio;
        longint base;
        longint cubic;
        longint unsigned p;
        longint unsigned coef;
        longint unsigned prod;
        longint s;
        t = (temperature > docu_pkg::TEMP_MAX_DEF) ? docu_pkg::TEMP_MAX_DEF : temperature;
        ratio = ((longint'(sample) - longint'(zero_offset)) * 65536) / longint'(slope);
        s = (ratio * 1000) / 65536;
        sat = (ratio < 0) ? 16'd0 : ((s > 65535) ? 16'hFFFF : s[15:0]);
        p = 64'd1 << 30;
        for (int i = 0; i < t; i++)
            p = (p * 64'd1012791180 + (64'd1 << 29)) >> 30;
        coef = ((64'd398721 * p) >> 30) + 64'd202113;
        base = ratio * 1462 - longint'(coef * salinity);
        if (base < 0)
        begin
            oxy = 16'd0;
            return;
        end
        cubic = (64'sd1 << 30) - 29500551 * t + 554376 * t * t - 4878 * t * t * t;
        if (cubic < 0)
            cubic = 0;
        prod = (longint'(base) * (longint'(cubic) >> 14)) >> 16;
        prod = (prod * pressure) / (64'd760 * 64'd65536);
        oxy = (prod > 65535) ? 16'hFFFF : prod[15:0];
    endfunction

    function void note_item(input docu_pkg::mode_t md, input logic [15:0] sample);
        logic [15:0] oxy;
        logic [15:0] sat;
        logic        err;
        oxy = 0;
        sat = 0;
        err = 0;
        case (md)
            docu_pkg::MODE_READ:
                if (slope == 0)
                    err = 1;
                else
                    compensate(sample, oxy, sat);
            docu_pkg::MODE_CAL_ATM:  slope = sample;
            docu_pkg::MODE_CAL_ZERO: zero_offset = sample;
            default:
            begin
                slope = docu_pkg::SLOPE_RESET;
                zero_offset = 0;
            end
        endcase
        exp_oxygen.push_back(oxy);
        exp_saturation.push_back(sat);
        exp_count.push_back(2'(slope != docu_pkg::SLOPE_RESET) + 2'(zero_offset != 0));
        exp_error.push_back(err);
    endfunction

    function void check_result(input logic [15:0] oxy, input logic [15:0] sat,
                               input logic [1:0] cnt, input logic err);
        logic [15:0] e_oxy;
        logic [15:0] e_sat;
        logic [1:0]  e_cnt;
        logic        e_err;
        if (exp_oxygen.size() == 0)
        begin
            $display("%0t: unexpected result oxygen %0d", $time, oxy);
            errors++;
            return;
        end
        e_oxy = exp_oxygen.pop_front();
        e_sat = exp_saturation.pop_front();
        e_cnt = exp_count.pop_front();
        e_err = exp_error.pop_front();
        checked++;
        if (oxy !== e_oxy)
        begin
            $display("%0t: oxygen_level expected %0d actual %0d", $time, e_oxy, oxy);
            errors++;
        end
        if (sat !== e_sat)
        begin
            $display("%0t: saturation_level expected %0d actual %0d", $time, e_sat, sat);
            errors++;
        end
        if (cnt !== e_cnt)
        begin
            $display("%0t: cal_count expected %0d actual %0d", $time, e_cnt, cnt);
            errors++;
        end
        if (err !== e_err)
        begin
            $display("%0t: slope_error expected %0d actual %0d", $time, e_err, err);
            errors++;
        end
    endfunction
endclass

module testbench;
    import docu_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [15:0] probe_sample;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] oxygen_level;
    logic [15:0] saturation_level;
    logic [1:0]  cal_count;
    logic        slope_error;

    oxygen_scoreboard board;
    int  cycles;
    bit  hold_receiver;
    bit  sink_quiet;
    int  reads;

    dissolved_oxygen_compensation_unit DUT (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(oxygen_level, saturation_level, cal_count, slope_error);

    initial
    begin
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
            begin
                out_stall <= 1;
                repeat (3000) @(negedge clk);
                hold_receiver = 0;
                out_stall <= 0;
            end
            else if (sink_quiet || $urandom_range(0, 3) != 0)
                out_stall <= 0;
            else
            begin
                out_stall <= 1;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 200)
                                                  : $urandom_range(1, 3)) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= 4'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_TEMP:     board.temperature = value[5:0];
            REG_PRESSURE: board.pressure = value[10:0];
            default:      board.salinity = value[5:0];
        endcase
    endtask

    task automatic send_item(input mode_t md, input logic [15:0] sample, input bit gaps);
        @(negedge clk);
        in_valid <= 1;
        mode <= md;
        probe_sample <= sample;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_item(md, sample);
        if (md == MODE_READ)
            reads++;
        if (gaps && $urandom_range(0, 2) == 0)
        begin
            @(negedge clk);
            in_valid <= 0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 300)
                                              : $urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (board.exp_oxygen.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_item();
        mode_t md;
        logic [15:0] sample;
        int pick;
        pick = $urandom_range(0, 19);
        md = pick < 14 ? MODE_READ : pick < 16 ? MODE_CAL_ATM : pick < 18 ? MODE_CAL_ZERO
                                                                            : MODE_CAL_CLEAR;
        sample = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
        if (md == MODE_CAL_ATM && $urandom_range(0, 9) == 0)
            sample = 0;
        send_item(md, sample, 1);
    endtask

    initial
    begin
        logic [31:0] temps[5];
        logic [31:0] press[5];
        logic [31:0] sals[5];
        board = new();
        board.clear_state();
        reads = 0;
        hold_receiver = 0;
        sink_quiet = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_valid = 0;
        mode = MODE_READ;
        probe_sample = 0;
        rst_n = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        sink_quiet = 1;
        send_item(MODE_READ, 16'd644, 0);
        send_item(MODE_READ, 16'd0, 0);
        send_item(MODE_READ, 16'hFFFF, 0);
        send_item(MODE_CAL_ZERO, 16'd100, 0);
        send_item(MODE_READ, 16'd50, 0);
        send_item(MODE_CAL_ATM, 16'd1, 0);
        send_item(MODE_READ, 16'hFFFF, 0);
        send_item(MODE_CAL_ATM, 16'd0, 0);
        send_item(MODE_READ, 16'd500, 0);
        send_item(MODE_CAL_ZERO, 16'hFFFF, 0);
        send_item(MODE_CAL_ATM, 16'hFFFF, 0);
        send_item(MODE_READ, 16'd0, 0);
        send_item(MODE_READ, 16'hFFFF, 0);
        send_item(MODE_CAL_CLEAR, 16'h5A5A, 0);
        send_item(MODE_READ, 16'd700, 0);
        drain();
        write_reg(REG_TEMP, 63);
        write_reg(REG_PRESSURE, 2047);
        write_reg(REG_SALINITY, 63);
        send_item(MODE_READ, 16'd644, 0);
        send_item(MODE_READ, 16'hFFFF, 0);
        send_item(MODE_CAL_ATM, 16'd2, 0);
        send_item(MODE_READ, 16'hFFFF, 0);
        drain();
        sink_quiet = 0;

        temps = '{0, 50, 7, 33, 20};
        press = '{0, 1500, 760, 300, 1100};
        sals  = '{0, 50, 35, 12, 0};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_TEMP, temps[ph]);
            write_reg(REG_PRESSURE, press[ph]);
            write_reg(REG_SALINITY, sals[ph]);
            if (ph == 2)
                hold_receiver = 1;
            for (int n = 0; n < 85; n++)
                random_item();
            drain();
        end

        $display("Covered %0d checked results (%0d reads) over seven register settings.",
                 board.checked, reads);
        $display("Included zero slope, negative offsets, register extremes and a long output hold.");
        if (board.errors == 0 && board.exp_oxygen.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
